// File: rtl/core/dhcv_pkg.sv
// Shared types and constants for the datagram header checksum validator.
// No dependencies; imported by every module of the block.
package dhcv_pkg;

  localparam int HDR_BYTES = 16;
  localparam int LEN_W     = 16;

  // Verdict codes, in the order the checks are applied
  localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
  localparam logic [2:0] VERDICT_SHORT    = 3'd1;
  localparam logic [2:0] VERDICT_LONG     = 3'd2;
  localparam logic [2:0] VERDICT_MAGIC    = 3'd3;
  localparam logic [2:0] VERDICT_SIZE     = 3'd4;
  localparam logic [2:0] VERDICT_CHECKSUM = 3'd5;

  // Register select (word address bit)
  localparam logic REG_MAGIC     = 1'b0;
  localparam logic REG_MAX_BYTES = 1'b1;

  localparam logic [15:0] MAGIC_RESET     = 16'h454E;
  localparam logic [10:0] MAX_BYTES_RESET = 11'd1400;

  // Header byte offsets of the checksum field (excluded from the sum)
  localparam int CKSUM_LO = 14;
  localparam int CKSUM_HI = 15;

  // Frame state after the byte in the input register has been applied
  typedef struct packed {
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [15:0]       sum;
    logic              overlong;
    logic [15:0][7:0]  hdr;
  } frame_sum_t;

endpackage

// File: rtl/core/dhcv_frame.sv
// Input register and per-byte frame tracking: position, byte sum, header capture.
// Depends on dhcv_pkg.
module dhcv_frame #(
  parameter int MAX_DATAGRAM = 2047
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  input  logic               end_of_datagram,
  input  logic               advance,
  input  logic [10:0]        max_datagram_bytes,
  output logic               held,
  output dhcv_pkg::frame_sum_t summary
);
  import dhcv_pkg::*;

  localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_DATAGRAM);

  logic             held_next;
  logic [7:0]       byte_q;
  logic             last_q;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      running_sum;
  logic [15:0]      running_sum_next;
  logic             overlong_seen;
  logic             overlong_seen_next;
  logic [POS_W:0]   pos_inc;
  logic             in_cksum;
  logic [7:0]       header_store [HDR_BYTES];

  assign held_next = take | (held & ~advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  // Payload of the input register: no reset
  always_ff @(posedge clk) begin
    if (take) begin
      byte_q <= rx_byte;
      last_q <= end_of_datagram;
    end
  end

  assign pos_inc  = {1'b0, byte_position} + (POS_W + 1)'(1);
  assign in_cksum = (byte_position == POS_W'(CKSUM_LO)) ||
                    (byte_position == POS_W'(CKSUM_HI));

  always_comb begin
    running_sum_next = in_cksum ? running_sum : running_sum + {8'd0, byte_q};
    if (byte_position >= POS_MAX) begin
      byte_position_next = byte_position;
      overlong_seen_next = 1'b1;
    end else begin
      byte_position_next = pos_inc[POS_W-1:0];
      overlong_seen_next = overlong_seen |
                           (LEN_W'(pos_inc) > LEN_W'(max_datagram_bytes));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      overlong_seen <= 1'b0;
    end else if (advance) begin
      if (last_q) begin
        byte_position <= '0;
        running_sum   <= '0;
        overlong_seen <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        running_sum   <= running_sum_next;
        overlong_seen <= overlong_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (byte_position < POS_W'(HDR_BYTES))) begin
      header_store[byte_position[3:0]] <= byte_q;
    end
  end

  // Forward the current byte into the header view when it is a header byte
  always_comb begin
    summary.last     = last_q;
    summary.len      = LEN_W'(byte_position_next);
    summary.sum      = running_sum_next;
    summary.overlong = overlong_seen_next;
    for (int i = 0; i < HDR_BYTES; i++) begin
      summary.hdr[i] = (byte_position == POS_W'(i)) ? byte_q : header_store[i];
    end
  end

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_MAX)
    else $error("byte position beyond datagram limit");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    advance && last_q |=> byte_position == '0 && running_sum == '0 && !overlong_seen)
    else $error("frame state not cleared after final byte");

endmodule

// File: rtl/core/dhcv_verdict.sv
// Datagram checks, accepted-traffic totals and the result register.
// Depends on dhcv_pkg.
module dhcv_verdict (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  dhcv_pkg::frame_sum_t summary,
  input  logic [15:0]          magic_word,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           verdict,
  output logic [7:0]           packet_kind,
  output logic [7:0]           header_flags,
  output logic                 wants_ack,
  output logic [15:0]          seq_number,
  output logic [15:0]          ack_number,
  output logic [31:0]          sender_time,
  output logic [10:0]          payload_length,
  output logic [31:0]          good_packet_total,
  output logic [31:0]          good_byte_total
);
  import dhcv_pkg::*;

  logic [2:0]  code;
  logic [15:0] hdr_magic;
  logic [15:0] hdr_size;
  logic [15:0] hdr_cksum;
  logic        good;
  logic [31:0] accepted_packets;
  logic [31:0] accepted_packets_next;
  logic [31:0] accepted_bytes;
  logic [31:0] accepted_bytes_next;

  assign hdr_magic = {summary.hdr[1],  summary.hdr[0]};
  assign hdr_size  = {summary.hdr[13], summary.hdr[12]};
  assign hdr_cksum = {summary.hdr[15], summary.hdr[14]};

  always_comb begin
    priority if (summary.len < LEN_W'(HDR_BYTES)) begin
      code = VERDICT_SHORT;
    end else if (summary.overlong) begin
      code = VERDICT_LONG;
    end else if (hdr_magic != magic_word) begin
      code = VERDICT_MAGIC;
    end else if (hdr_size != summary.len - LEN_W'(HDR_BYTES)) begin
      code = VERDICT_SIZE;
    end else if (hdr_cksum != summary.sum) begin
      code = VERDICT_CHECKSUM;
    end else begin
      code = VERDICT_ACCEPT;
    end
  end

  assign good                  = (code == VERDICT_ACCEPT);
  assign accepted_packets_next = accepted_packets + 32'd1;
  assign accepted_bytes_next   = accepted_bytes + 32'(summary.len);

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_packets <= '0;
      accepted_bytes   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (load && good) begin
        accepted_packets <= accepted_packets_next;
        accepted_bytes   <= accepted_bytes_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: zero every field but the verdict on a reject
  always_ff @(posedge clk) begin
    if (load) begin
      verdict           <= code;
      packet_kind       <= good ? summary.hdr[2] : 8'd0;
      header_flags      <= good ? summary.hdr[3] : 8'd0;
      wants_ack         <= good & summary.hdr[3][0];
      seq_number        <= good ? {summary.hdr[5], summary.hdr[4]} : 16'd0;
      ack_number        <= good ? {summary.hdr[7], summary.hdr[6]} : 16'd0;
      sender_time       <= good ? {summary.hdr[11], summary.hdr[10],
                                   summary.hdr[9], summary.hdr[8]} : 32'd0;
      payload_length    <= good ? hdr_size[10:0] : 11'd0;
      good_packet_total <= good ? accepted_packets_next : 32'd0;
      good_byte_total   <= good ? accepted_bytes_next : 32'd0;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_ACCEPT |->
      good_packet_total == '0 && good_byte_total == '0 && !wants_ack)
    else $error("rejected result carries nonzero fields");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    load && good |=> accepted_packets == $past(accepted_packets) + 32'd1)
    else $error("accepted packet count did not advance");

  a_accept_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_ACCEPT |->
      wants_ack == header_flags[0] && good_packet_total == accepted_packets &&
      good_byte_total == accepted_bytes)
    else $error("accepted result disagrees with running totals");

endmodule

// File: rtl/core/datagram_header_checksum_validator_core.sv
// Top level of the datagram header checksum validator: APB registers and the
// two-stage byte path. Depends on dhcv_pkg, dhcv_frame and dhcv_verdict.
//
// The block takes one datagram byte per transfer on the input channel and
// sustains one byte per clock cycle except while a final byte waits on the
// output. Each byte lands in an input register; from there it is folded into
// the frame state (position, 16-bit byte sum, header capture) and, on the byte
// flagged end_of_datagram, the checks run and the result register is loaded.
// The path from the input register to the result register (16-bit byte sum,
// 16-bit compares, 32-bit totals and header field selection) is combinational.
// Bytes that are not final never wait on the output; a final byte waits only
// while a previous result is still held and not taken. Registers: magic_word
// at byte address 0 and max_datagram_bytes at address 4; the user must write
// them only while the block is idle, which the block does not enforce. The
// header store needs no clearing pass after reset.
module datagram_header_checksum_validator_core #(
  parameter int MAX_DATAGRAM = 2047
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_datagram,
  // verdict output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [7:0]  packet_kind,
  output logic [7:0]  header_flags,
  output logic        wants_ack,
  output logic [15:0] seq_number,
  output logic [15:0] ack_number,
  output logic [31:0] sender_time,
  output logic [10:0] payload_length,
  output logic [31:0] good_packet_total,
  output logic [31:0] good_byte_total
);
  import dhcv_pkg::*;

  logic        cfg_write;
  logic [15:0] magic_word;
  logic [10:0] max_datagram_bytes;
  logic        take;
  logic        held;
  logic        advance;
  frame_sum_t  summary;

  // Configuration registers: write on the access phase, zero wait states
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word         <= MAGIC_RESET;
      max_datagram_bytes <= MAX_BYTES_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_MAGIC:     magic_word         <= pwdata[15:0];
        REG_MAX_BYTES: max_datagram_bytes <= pwdata[10:0];
        default:       magic_word         <= magic_word;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAGIC:     prdata = {16'd0, magic_word};
      REG_MAX_BYTES: prdata = {21'd0, max_datagram_bytes};
      default:       prdata = '0;
    endcase
  end

  // Advance the held byte unless it would produce a result while the
  // result register is still full and not being taken; hold otherwise.
  assign advance  = held & (~summary.last | ~out_valid | out_ready);
  assign in_ready = ~held | advance;
  assign take     = in_valid & in_ready;

  dhcv_frame #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_frame (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .rx_byte            (rx_byte),
    .end_of_datagram    (end_of_datagram),
    .advance            (advance),
    .max_datagram_bytes (max_datagram_bytes),
    .held               (held),
    .summary            (summary)
  );

  // Load the result register on the final byte of each datagram
  dhcv_verdict u_verdict (
    .clk               (clk),
    .rst               (rst),
    .load              (advance & summary.last),
    .summary           (summary),
    .magic_word        (magic_word),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .verdict           (verdict),
    .packet_kind       (packet_kind),
    .header_flags      (header_flags),
    .wants_ack         (wants_ack),
    .seq_number        (seq_number),
    .ack_number        (ack_number),
    .sender_time       (sender_time),
    .payload_length    (payload_length),
    .good_packet_total (good_packet_total),
    .good_byte_total   (good_byte_total)
  );

endmodule
